@@ rtl/core/stxp_pkg.sv @@
// shared types and constants for the spi transmit word packer
package stxp_pkg;

   // unit size codes
   localparam logic [1:0] SIZE_ONE  = 2'd0;
   localparam logic [1:0] SIZE_TWO  = 2'd1;
   localparam logic [1:0] SIZE_FOUR = 2'd2;

   // how many units one request can produce
   localparam logic [1:0] PUSH_NONE = 2'd0;
   localparam logic [1:0] PUSH_ONE  = 2'd1;
   localparam logic [1:0] PUSH_TWO  = 2'd2;

   // result queue geometry
   localparam int unsigned FIFO_DEPTH = 8;
   localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
   // room for the unit pair of a request in the stage plus one more pair
   localparam logic [FIFO_AW:0] ACCEPT_LIMIT = (FIFO_AW + 1)'(FIFO_DEPTH - 4);

   // configuration register map
   localparam int unsigned CSR_AW = 2;
   localparam logic [CSR_AW-1:0] CSR_ADDR_BYTE_ORDER = '0;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_transfer;
      logic       last_transfer;
      logic       quad_lanes;
   } req_type;

   typedef struct packed {
      logic [31:0] write_word;
      logic [1:0]  unit_size;
      logic        quad_data;
      logic        keep_select;
      logic        last_of_run;
   } rsp_type;

   // units handed from the packer to the result queue in one cycle
   typedef struct packed {
      logic [1:0] num;
      rsp_type    first;
      rsp_type    second;
   } push_type;

endpackage

@@ rtl/core/spi_tx_word_packer_core.sv @@
// top level of the spi transmit word packer
// Packs transmit bytes into write units for a serial flash controller. One
// request (a byte with its end-of-transfer, last-transfer and quad flags) is
// taken per cycle when the result queue has room; it lands in a stage
// register, the packer logic forms zero, one or two units from it and the
// held bytes, and those units enter an eight-entry result queue that drives
// the rsp channel. Every fourth byte of a transfer yields a 32-bit unit; at
// end of transfer a tail of one or two bytes yields one unit and a tail of
// three yields a halfword unit then a byte unit. A request goes through the
// stage register and then the result queue on its way to the rsp channel.
// Sustained rate is one request per cycle while req_stall is low; the queue
// takes two units per cycle but hands out at most one. req_stall comes from
// the registered queue fill only. The byte order register (low_order_first,
// byte address 0) must only be written while idle.
module spi_tx_word_packer_core (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  stxp_pkg::req_type                 req_data,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output stxp_pkg::rsp_type                 rsp_data,
   // configuration port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [stxp_pkg::CSR_AW-1:0]       paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);

   logic                            lof_ff;
   logic                            lof_in;
   logic                            item_valid_ff;
   logic                            item_valid_in;
   stxp_pkg::req_type               item_ff;
   logic [7:0]                      held_ff [3];
   logic [1:0]                      held_cnt_ff;
   logic [1:0]                      held_cnt_in;
   logic [1:0]                      held_cnt_next;
   logic                            held_wr;
   logic                            req_accept;
   logic                            csr_write;
   stxp_pkg::push_type              pack_push;
   stxp_pkg::push_type              push;
   logic [stxp_pkg::FIFO_AW:0]      fifo_count;

   // configuration register, always ready
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready
                      & (paddr == stxp_pkg::CSR_ADDR_BYTE_ORDER);
   assign lof_in    = csr_write ? pwdata[0] : lof_ff;
   assign prdata    = (paddr == stxp_pkg::CSR_ADDR_BYTE_ORDER) ? {31'h0, lof_ff} : 32'h0;

   // request side: stall only when queue cannot absorb two more pairs
   assign req_stall     = (fifo_count > stxp_pkg::ACCEPT_LIMIT);
   assign req_accept    = req_valid & ~req_stall;
   assign item_valid_in = req_accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         lof_ff        <= 1'b0;
         item_valid_ff <= 1'b0;
         held_cnt_ff   <= 2'd0;
      end else begin
         lof_ff        <= lof_in;
         item_valid_ff <= item_valid_in;
         held_cnt_ff   <= held_cnt_in;
      end
   end

   // stage register for the accepted request
   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= req_data;
      end
   end

   stxp_pack u_pack (
      .low_order_first (lof_ff),
      .item            (item_ff),
      .held0           (held_ff[0]),
      .held1           (held_ff[1]),
      .held2           (held_ff[2]),
      .held_cnt        (held_cnt_ff),
      .push            (pack_push),
      .held_cnt_next   (held_cnt_next),
      .held_wr         (held_wr)
   );

   // packer output only counts when the stage holds a request
   always_comb begin
      push = pack_push;
      if (!item_valid_ff) begin
         push.num = stxp_pkg::PUSH_NONE;
      end
   end

   assign held_cnt_in = item_valid_ff ? held_cnt_next : held_cnt_ff;

   // held byte storage, written at the slot after the held ones
   always_ff @(posedge clock) begin
      if (item_valid_ff && held_wr) begin
         held_ff[held_cnt_ff] <= item_ff.data_byte;
      end
   end

   stxp_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (~rsp_stall),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .count     (fifo_count)
   );

   // queue never overflows
   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_count <= (stxp_pkg::FIFO_AW + 1)'(stxp_pkg::FIFO_DEPTH))
      else $error("result queue overflow");

   // an end-of-transfer request always empties the held bytes
   a_eot_flush: assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && item_ff.end_of_transfer |=> held_cnt_ff == 2'd0)
      else $error("held bytes left after end of transfer");

   // a group of four always leaves as one full word
   a_full_group: assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && held_cnt_ff == 2'd3 |->
         push.num == stxp_pkg::PUSH_ONE && push.first.unit_size == stxp_pkg::SIZE_FOUR)
      else $error("full group not sent as word");

   // byte units carry zero upper bits
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.unit_size == stxp_pkg::SIZE_ONE |->
         rsp_data.write_word[31:8] == 24'h000000)
      else $error("byte unit with nonzero upper bits");

   // an accepted request is in the stage next cycle
   a_stage_load: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> item_valid_ff)
      else $error("accepted request lost");

endmodule

@@ rtl/core/stxp_pack.sv @@
// byte grouping and unit formation for one request
module stxp_pack (
   input  logic                 low_order_first,
   input  stxp_pkg::req_type    item,
   input  logic [7:0]           held0,
   input  logic [7:0]           held1,
   input  logic [7:0]           held2,
   input  logic [1:0]           held_cnt,
   output stxp_pkg::push_type   push,
   output logic [1:0]           held_cnt_next,
   output logic                 held_wr
);

   logic [7:0]  g0;
   logic [7:0]  g1;
   logic [7:0]  g2;
   logic [7:0]  g3;
   logic [31:0] pack4;
   logic [31:0] pack2;
   logic        final_keep;

   // new byte takes the slot after the held ones
   assign g0 = (held_cnt == 2'd0) ? item.data_byte : held0;
   assign g1 = (held_cnt == 2'd1) ? item.data_byte : held1;
   assign g2 = (held_cnt == 2'd2) ? item.data_byte : held2;
   assign g3 = item.data_byte;

   assign pack4 = low_order_first ? {g3, g2, g1, g0} : {g0, g1, g2, g3};
   assign pack2 = low_order_first ? {16'h0000, g1, g0} : {16'h0000, g0, g1};

   assign final_keep = ~(item.end_of_transfer & item.last_transfer);

   always_comb begin
      push                    = '0;
      push.first.quad_data    = item.quad_lanes;
      push.second.quad_data   = item.quad_lanes;
      push.first.keep_select  = final_keep;
      push.first.last_of_run  = 1'b1;
      push.second.keep_select = final_keep;
      push.second.last_of_run = 1'b1;
      held_cnt_next           = 2'd0;
      held_wr                 = 1'b0;
      priority if (held_cnt == 2'd3) begin
         push.num              = stxp_pkg::PUSH_ONE;
         push.first.write_word = pack4;
         push.first.unit_size  = stxp_pkg::SIZE_FOUR;
      end else if (!item.end_of_transfer) begin
         held_wr       = 1'b1;
         held_cnt_next = held_cnt + 2'd1;
      end else if (held_cnt == 2'd2) begin
         // three-byte tail: halfword then byte
         push.num                = stxp_pkg::PUSH_TWO;
         push.first.write_word   = pack2;
         push.first.unit_size    = stxp_pkg::SIZE_TWO;
         push.first.keep_select  = 1'b1;
         push.first.last_of_run  = 1'b0;
         push.second.write_word  = {24'h000000, g2};
         push.second.unit_size   = stxp_pkg::SIZE_ONE;
      end else if (held_cnt == 2'd1) begin
         push.num              = stxp_pkg::PUSH_ONE;
         push.first.write_word = pack2;
         push.first.unit_size  = stxp_pkg::SIZE_TWO;
      end else begin
         push.num              = stxp_pkg::PUSH_ONE;
         push.first.write_word = {24'h000000, g0};
         push.first.unit_size  = stxp_pkg::SIZE_ONE;
      end
   end

endmodule

@@ rtl/core/stxp_rsp_fifo.sv @@
// small result queue taking up to two units per cycle
module stxp_rsp_fifo (
   input  logic                            clock,
   input  logic                            reset,
   input  stxp_pkg::push_type              push,
   input  logic                            pop,
   output logic                            out_valid,
   output stxp_pkg::rsp_type               out_data,
   output logic [stxp_pkg::FIFO_AW:0]      count
);

   stxp_pkg::rsp_type               mem_ff [stxp_pkg::FIFO_DEPTH];
   logic [stxp_pkg::FIFO_AW-1:0]    wr_ptr_ff;
   logic [stxp_pkg::FIFO_AW-1:0]    wr_ptr_in;
   logic [stxp_pkg::FIFO_AW-1:0]    rd_ptr_ff;
   logic [stxp_pkg::FIFO_AW-1:0]    rd_ptr_in;
   logic [stxp_pkg::FIFO_AW:0]      count_ff;
   logic [stxp_pkg::FIFO_AW:0]      count_in;
   logic [stxp_pkg::FIFO_AW-1:0]    wr_ptr_nxt;
   logic                            do_pop;

   assign out_valid  = (count_ff != '0);
   assign out_data   = mem_ff[rd_ptr_ff];
   assign count      = count_ff;
   assign do_pop     = pop & out_valid;
   assign wr_ptr_nxt = wr_ptr_ff + stxp_pkg::FIFO_AW'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + stxp_pkg::FIFO_AW'(push.num);
      rd_ptr_in = rd_ptr_ff + stxp_pkg::FIFO_AW'(do_pop);
      count_in  = count_ff + (stxp_pkg::FIFO_AW + 1)'(push.num)
                  - (stxp_pkg::FIFO_AW + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.num != stxp_pkg::PUSH_NONE) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.num == stxp_pkg::PUSH_TWO) begin
         mem_ff[wr_ptr_nxt] <= push.second;
      end
   end

endmodule
